// ----- src/rpn_pkg.sv -----
// Package: constants, codes and shared types for the route pattern normaliser.
package rpn_pkg;

  localparam int unsigned MAX_LEN = 1024;
  localparam int unsigned CNT_W = $clog2(MAX_LEN + 1);
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);

  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  typedef enum logic [2:0] {
    ST_OK = 3'd0,
    ST_BAD_START = 3'd1,
    ST_TOO_LONG = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_NESTED = 3'd4,
    ST_EMPTY_NAME = 3'd5,
    ST_STRAY_CLOSE = 3'd6,
    ST_UNTERMINATED = 3'd7
  } status_t;

  typedef enum logic [2:0] {
    MODE_LIT = 3'd0,
    MODE_CNAME = 3'd1,
    MODE_BNAME = 3'd2,
    MODE_BCONS = 3'd3,
    MODE_PAREN = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic byte_valid;
    logic end_mark;
    logic [2:0] status;
  } result_t;

  // one to two results produced by one input byte
  typedef struct packed {
    logic two;
    result_t r0;
    result_t r1;
  } bundle_t;

  typedef struct packed {
    logic [1:0] n;
    logic [7:0] b0;
    logic [7:0] b1;
  } emits_t;

  typedef struct packed {
    logic emit;
    logic [7:0] eb;
    mode_t mode;
    logic clr_name;
    status_t err;
  } lit_t;

  function automatic emits_t append(emits_t e, logic [7:0] b);
    emits_t r;
    r = e;
    if (e.n == 2'd0) begin
      r.b0 = b;
      r.n = 2'd1;
    end else if (e.n == 2'd1) begin
      r.b1 = b;
      r.n = 2'd2;
    end
    return r;
  endfunction

  function automatic logic is_name_char(logic [7:0] c);
    return (c inside {[8'h30:8'h39], [8'h41:8'h5A], [8'h61:8'h7A]}) || (c == CH_UNDER);
  endfunction

  function automatic lit_t literal_byte(logic [7:0] c, logic prev_slash);
    lit_t l;
    l.emit = 1'b0;
    l.eb = c;
    l.mode = MODE_LIT;
    l.clr_name = 1'b0;
    l.err = ST_OK;
    if (c == CH_LBRACE) begin
      l.emit = 1'b1;
      l.mode = MODE_BNAME;
      l.clr_name = 1'b1;
    end else if (c == CH_RBRACE) begin
      l.err = ST_STRAY_CLOSE;
    end else if (c == CH_COLON && prev_slash) begin
      l.emit = 1'b1;
      l.eb = CH_LBRACE;
      l.mode = MODE_CNAME;
      l.clr_name = 1'b1;
    end else begin
      l.emit = 1'b1;
    end
    return l;
  endfunction

endpackage

// ----- src/rpn_in_if.sv -----
// Input channel interface: pattern bytes with valid/ready handshake.
interface rpn_in_if;
  logic valid;
  logic ready;
  logic [7:0] in_byte;
  logic last;

  modport source (output valid, output in_byte, output last, input ready);
  modport sink (input valid, input in_byte, input last, output ready);
endinterface

// ----- src/rpn_out_if.sv -----
// Output channel interface: normalised bytes and end status with valid/ready handshake.
interface rpn_out_if;
  logic valid;
  logic ready;
  logic [7:0] out_byte;
  logic byte_valid;
  logic end_mark;
  logic [2:0] status;

  modport source (output valid, output out_byte, output byte_valid, output end_mark,
                  output status, input ready);
  modport sink (input valid, input out_byte, input byte_valid, input end_mark,
                input status, output ready);
endinterface

// ----- src/rpn_front.sv -----
// Front end: parses each accepted byte and builds the bundle of results it causes.
module rpn_front (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  input  logic [7:0] in_byte,
  input  logic in_last,
  input  logic accept,
  output logic push,
  output rpn_pkg::bundle_t bundle
);
  import rpn_pkg::*;

  mode_t mode, mode_next;
  logic name_seen, name_seen_next;
  logic [CNT_W-1:0] paren_depth, paren_depth_next;
  logic prev_slash, prev_slash_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  status_t error_code, error_code_next;

  logic [CNT_W-1:0] cnt_inc;
  lit_t lit;
  emits_t em;
  status_t err;
  logic [1:0] nres;

  always_comb begin
    lit = literal_byte(in_byte, prev_slash);
    cnt_inc = (byte_count < CNT_W'(MAX_LEN)) ? byte_count + 1'b1 : byte_count;
    mode_next = mode;
    name_seen_next = name_seen;
    paren_depth_next = paren_depth;
    byte_count_next = byte_count;
    err = error_code;
    em = '0;

    if (error_code == ST_OK) begin
      if (byte_count == '0 && in_byte != CH_SLASH) begin
        err = ST_BAD_START;
      end else begin
        byte_count_next = cnt_inc;
        if (cnt_inc >= CNT_W'(MAX_LEN)) begin
          err = ST_TOO_LONG;
        end else begin
          case (mode)
            MODE_CNAME: begin
              if (is_name_char(in_byte)) begin
                em = append(em, in_byte);
                name_seen_next = 1'b1;
              end else if (!name_seen) begin
                err = ST_EMPTY_NAME;
              end else begin
                em = append(em, CH_RBRACE);
                if (in_byte == CH_LPAREN) begin
                  mode_next = MODE_PAREN;
                  paren_depth_next = CNT_W'(1);
                end else begin
                  mode_next = lit.mode;
                  if (lit.clr_name) name_seen_next = 1'b0;
                  if (lit.emit) em = append(em, lit.eb);
                  err = lit.err;
                end
              end
            end
            MODE_BNAME: begin
              if (in_byte == CH_LBRACE) begin
                err = ST_NESTED;
              end else if (in_byte == CH_RBRACE || in_byte == CH_COLON) begin
                if (!name_seen) begin
                  err = ST_EMPTY_NAME;
                end else if (in_byte == CH_RBRACE) begin
                  em = append(em, CH_RBRACE);
                  mode_next = MODE_LIT;
                end else begin
                  mode_next = MODE_BCONS;
                end
              end else begin
                em = append(em, in_byte);
                name_seen_next = 1'b1;
              end
            end
            MODE_BCONS: begin
              if (in_byte == CH_LBRACE) begin
                err = ST_NESTED;
              end else if (in_byte == CH_RBRACE) begin
                em = append(em, CH_RBRACE);
                mode_next = MODE_LIT;
              end
            end
            MODE_PAREN: begin
              if (in_byte == CH_LPAREN) begin
                paren_depth_next = paren_depth + 1'b1;
              end else if (in_byte == CH_RPAREN) begin
                if (paren_depth != '0) paren_depth_next = paren_depth - 1'b1;
                if (paren_depth_next == '0) mode_next = MODE_LIT;
              end
            end
            default: begin
              mode_next = lit.mode;
              if (lit.clr_name) name_seen_next = 1'b0;
              if (lit.emit) em = append(em, lit.eb);
              err = lit.err;
            end
          endcase
        end
      end
      if (err == ST_OK && in_last) begin
        case (mode_next)
          MODE_CNAME: begin
            if (!name_seen_next) err = ST_EMPTY_NAME;
            else em = append(em, CH_RBRACE);
          end
          MODE_BNAME: err = ST_UNCLOSED;
          MODE_BCONS, MODE_PAREN: err = ST_UNTERMINATED;
          default: ;
        endcase
      end
      if (err != ST_OK) em = '0;
    end

    error_code_next = err;
    prev_slash_next = (in_byte == CH_SLASH);
    if (in_last) begin
      mode_next = MODE_LIT;
      name_seen_next = 1'b0;
      paren_depth_next = '0;
      byte_count_next = '0;
      error_code_next = ST_OK;
      prev_slash_next = 1'b0;
    end

    // results: emitted bytes, then end marker riding on the last or standing alone
    bundle = '0;
    bundle.r0.out_byte = em.b0;
    bundle.r0.byte_valid = (em.n != 2'd0);
    bundle.r1.out_byte = em.b1;
    bundle.r1.byte_valid = (em.n == 2'd2);
    nres = em.n;
    if (in_last) begin
      if (em.n == 2'd0) begin
        bundle.r0.end_mark = 1'b1;
        bundle.r0.status = err;
        nres = 2'd1;
      end else if (em.n == 2'd1) begin
        bundle.r0.end_mark = 1'b1;
      end else begin
        bundle.r1.end_mark = 1'b1;
      end
    end
    bundle.two = (nres == 2'd2);
    push = accept && in_valid && (nres != 2'd0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_LIT;
      name_seen <= 1'b0;
      paren_depth <= '0;
      prev_slash <= 1'b0;
      byte_count <= '0;
      error_code <= ST_OK;
    end else if (accept && in_valid) begin
      mode <= mode_next;
      name_seen <= name_seen_next;
      paren_depth <= paren_depth_next;
      prev_slash <= prev_slash_next;
      byte_count <= byte_count_next;
      error_code <= error_code_next;
    end
  end

endmodule

// ----- src/rpn_queue.sv -----
// Bundle queue between front and back ends.
module rpn_queue (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  rpn_pkg::bundle_t push_data,
  output logic full,
  input  logic pop,
  output logic nonempty,
  output rpn_pkg::bundle_t head
);
  import rpn_pkg::*;

  bundle_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QPTR_W:0] fill;
  logic do_push, do_pop;

  assign full = (fill == (QPTR_W+1)'(QDEPTH));
  assign nonempty = (fill != '0);
  assign head = mem[rd_ptr];
  assign do_push = push && !full;
  assign do_pop = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) fill <= fill + 1'b1;
      else if (do_pop && !do_push) fill <= fill - 1'b1;
    end
  end

endmodule

// ----- src/rpn_back.sv -----
// Back end: unpacks each queued bundle into one or two output transactions.
module rpn_back (
  input  logic clk,
  input  logic rst,
  input  logic nonempty,
  input  rpn_pkg::bundle_t head,
  output logic pop,
  output logic out_valid,
  input  logic out_ready,
  output rpn_pkg::result_t res
);
  import rpn_pkg::*;

  logic sel;
  logic fire;

  assign out_valid = nonempty;
  assign res = sel ? head.r1 : head.r0;
  assign fire = out_valid && out_ready;
  assign pop = fire && (sel || !head.two);

  always_ff @(posedge clk) begin
    if (rst) begin
      sel <= 1'b0;
    end else if (fire) begin
      sel <= !pop;
    end
  end

endmodule

// ----- src/route_pattern_normalizer.sv -----
// Top level: route pattern normaliser, front parser, bundle queue and output unpacker.
// A byte's first result is registered in the bundle queue and offered once its bundle reaches the head.
// Throughput: one byte per cycle in; one result per cycle out while out_ch.ready is high, a byte causes 0 to 2 results.
// The four-entry queue decouples the sides; input stalls only when the queue is full.
// Reset (rst, synchronous) empties the queue and returns the parser to literal mode.
module route_pattern_normalizer (
  input logic clk,
  input logic rst,
  rpn_in_if.sink in_ch,
  rpn_out_if.source out_ch
);
  import rpn_pkg::*;

  logic push, full, pop, nonempty;
  bundle_t bundle, head;
  result_t res;

  assign in_ch.ready = !full;

  rpn_front u_front (
    .clk(clk),
    .rst(rst),
    .in_valid(in_ch.valid),
    .in_byte(in_ch.in_byte),
    .in_last(in_ch.last),
    .accept(!full),
    .push(push),
    .bundle(bundle)
  );

  rpn_queue u_queue (
    .clk(clk),
    .rst(rst),
    .push(push),
    .push_data(bundle),
    .full(full),
    .pop(pop),
    .nonempty(nonempty),
    .head(head)
  );

  rpn_back u_back (
    .clk(clk),
    .rst(rst),
    .nonempty(nonempty),
    .head(head),
    .pop(pop),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .res(res)
  );

  assign out_ch.out_byte = res.out_byte;
  assign out_ch.byte_valid = res.byte_valid;
  assign out_ch.end_mark = res.end_mark;
  assign out_ch.status = res.status;

endmodule

// ----- test/tb.sv -----
// Testbench for route_pattern_normalizer: directed and random route patterns, predicted output.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import rpn_pkg::*;

  typedef struct {
    logic [7:0] b;
    logic fin;
  } byte_item_t;

  logic clk;
  logic rst;

  rpn_in_if in_ch();
  rpn_out_if out_ch();

  route_pattern_normalizer u_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  byte_item_t pending[$];
  logic [7:0] pat[$];
  result_t due[$];
  logic [7:0] emitted[$];

  // predictor state
  mode_t nm_mode = MODE_LIT;
  logic nm_seen = 1'b0;
  int unsigned nm_depth = 0;
  logic nm_prev_slash = 1'b0;
  int unsigned nm_count = 0;
  status_t nm_err = ST_OK;

  int sent = 0;
  int patterns_done = 0;
  int checked = 0;
  int mismatches = 0;
  int status_seen[8];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic is_word_char(logic [7:0] c);
    return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
           (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
  endfunction

  function automatic void emit_byte(logic [7:0] c);
    if (emitted.size() < 2) emitted.push_back(c);
  endfunction

  function automatic void plain_byte(logic [7:0] c);
    if (c == CH_LBRACE) begin
      emit_byte(CH_LBRACE);
      nm_mode = MODE_BNAME;
      nm_seen = 1'b0;
    end else if (c == CH_RBRACE) begin
      nm_err = ST_STRAY_CLOSE;
    end else if (c == CH_COLON && nm_prev_slash) begin
      emit_byte(CH_LBRACE);
      nm_mode = MODE_CNAME;
      nm_seen = 1'b0;
    end else begin
      emit_byte(c);
    end
  endfunction

  function automatic void consume(logic [7:0] c);
    case (nm_mode)
      MODE_CNAME: begin
        if (is_word_char(c)) begin
          emit_byte(c);
          nm_seen = 1'b1;
        end else if (!nm_seen) begin
          nm_err = ST_EMPTY_NAME;
        end else begin
          emit_byte(CH_RBRACE);
          if (c == CH_LPAREN) begin
            nm_mode = MODE_PAREN;
            nm_depth = 1;
          end else begin
            nm_mode = MODE_LIT;
            plain_byte(c);
          end
        end
      end
      MODE_BNAME: begin
        if (c == CH_LBRACE) begin
          nm_err = ST_NESTED;
        end else if (c == CH_RBRACE || c == CH_COLON) begin
          if (!nm_seen) begin
            nm_err = ST_EMPTY_NAME;
          end else if (c == CH_RBRACE) begin
            emit_byte(CH_RBRACE);
            nm_mode = MODE_LIT;
          end else begin
            nm_mode = MODE_BCONS;
          end
        end else begin
          emit_byte(c);
          nm_seen = 1'b1;
        end
      end
      MODE_BCONS: begin
        if (c == CH_LBRACE) begin
          nm_err = ST_NESTED;
        end else if (c == CH_RBRACE) begin
          emit_byte(CH_RBRACE);
          nm_mode = MODE_LIT;
        end
      end
      MODE_PAREN: begin
        if (c == CH_LPAREN) begin
          nm_depth++;
        end else if (c == CH_RPAREN) begin
          if (nm_depth > 0) nm_depth--;
          if (nm_depth == 0) nm_mode = MODE_LIT;
        end
      end
      default: plain_byte(c);
    endcase
  endfunction

  function automatic void close_pattern();
    case (nm_mode)
      MODE_CNAME: begin
        if (!nm_seen) nm_err = ST_EMPTY_NAME;
        else emit_byte(CH_RBRACE);
      end
      MODE_BNAME: nm_err = ST_UNCLOSED;
      MODE_BCONS, MODE_PAREN: nm_err = ST_UNTERMINATED;
      default: ;
    endcase
  endfunction

  // works out the output transactions that one accepted byte causes
  function automatic void normalise_byte(logic [7:0] c, logic fin);
    result_t r;
    emitted.delete();
    if (nm_err == ST_OK) begin
      if (nm_count == 0 && c != CH_SLASH) begin
        nm_err = ST_BAD_START;
      end else begin
        if (nm_count < MAX_LEN) nm_count++;
        if (nm_count >= MAX_LEN) nm_err = ST_TOO_LONG;
        else consume(c);
      end
      if (nm_err == ST_OK && fin) close_pattern();
      if (nm_err != ST_OK) emitted.delete();
    end
    nm_prev_slash = (c == CH_SLASH);
    for (int k = 0; k < emitted.size(); k++) begin
      r.out_byte = emitted[k];
      r.byte_valid = 1'b1;
      r.end_mark = fin && nm_err == ST_OK && k == emitted.size() - 1;
      r.status = ST_OK;
      due.push_back(r);
    end
    if (fin) begin
      if (emitted.size() == 0 || nm_err != ST_OK) begin
        r = '0;
        r.end_mark = 1'b1;
        r.status = nm_err;
        due.push_back(r);
      end
      nm_mode = MODE_LIT;
      nm_seen = 1'b0;
      nm_depth = 0;
      nm_prev_slash = 1'b0;
      nm_count = 0;
      nm_err = ST_OK;
    end
  endfunction

  function automatic logic [7:0] rnd_name_char();
    case ($urandom_range(0, 3))
      0: return 8'h30 + 8'($urandom_range(0, 9));
      1: return 8'h41 + 8'($urandom_range(0, 25));
      2: return 8'h61 + 8'($urandom_range(0, 25));
      default: return CH_UNDER;
    endcase
  endfunction

  function automatic logic [7:0] rnd_special();
    case ($urandom_range(0, 6))
      0: return CH_LBRACE;
      1: return CH_RBRACE;
      2: return CH_COLON;
      3: return CH_LPAREN;
      4: return CH_RPAREN;
      5: return CH_SLASH;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [7:0] rnd_except(logic [7:0] x, logic [7:0] y, logic [7:0] z);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == x || c == y || c == z);
    return c;
  endfunction

  task automatic flush_pattern();
    byte_item_t it;
    for (int i = 0; i < pat.size(); i++) begin
      it.b = pat[i];
      it.fin = (i == pat.size() - 1);
      pending.push_back(it);
    end
    pat.delete();
  endtask

  task automatic directed(string s);
    for (int i = 0; i < s.len(); i++) pat.push_back(s[i]);
    flush_pattern();
  endtask

  task automatic add_long(int len);
    pat.push_back(CH_SLASH);
    repeat (len - 1) pat.push_back(rnd_name_char());
    flush_pattern();
  endtask

  task automatic gen_paren();
    int open;
    int r;
    pat.push_back(CH_LPAREN);
    open = 1;
    repeat ($urandom_range(0, 6)) begin
      r = $urandom_range(0, 9);
      if (r < 2 && open < 4) begin
        pat.push_back(CH_LPAREN);
        open++;
      end else if (r < 4 && open > 1) begin
        pat.push_back(CH_RPAREN);
        open--;
      end else begin
        pat.push_back(rnd_except(CH_LPAREN, CH_RPAREN, CH_RPAREN));
      end
    end
    repeat (open) pat.push_back(CH_RPAREN);
  endtask

  task automatic gen_route();
    repeat ($urandom_range(1, 4)) begin
      pat.push_back(CH_SLASH);
      case ($urandom_range(0, 4))
        0: repeat ($urandom_range(0, 5)) pat.push_back(rnd_name_char());
        1: begin
          pat.push_back(CH_COLON);
          repeat ($urandom_range(1, 6)) pat.push_back(rnd_name_char());
          if ($urandom_range(0, 99) < 40) gen_paren();
        end
        2: begin
          pat.push_back(CH_LBRACE);
          repeat ($urandom_range(1, 5)) pat.push_back(rnd_except(CH_LBRACE, CH_RBRACE, CH_COLON));
          if ($urandom_range(0, 1)) begin
            pat.push_back(CH_COLON);
            repeat ($urandom_range(0, 4))
              pat.push_back(rnd_except(CH_LBRACE, CH_RBRACE, CH_RBRACE));
          end
          pat.push_back(CH_RBRACE);
        end
        3: begin
          pat.push_back(rnd_name_char());
          pat.push_back(CH_COLON);
          pat.push_back(rnd_name_char());
        end
        default: repeat ($urandom_range(1, 3))
          pat.push_back(rnd_except(CH_LBRACE, CH_RBRACE, CH_COLON));
      endcase
    end
  endtask

  task automatic flag(string msg);
    mismatches++;
    if (mismatches <= 30) $error("%s", msg);
  endtask

  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want !== got) flag($sformatf("%s: expected %0h, got %0h", name, want, got));
  endtask

  // both sides run flat out here
  function automatic bit burst_window();
    return sent >= 700 && sent < 1000;
  endfunction

  always @(posedge clk) begin : drive
    byte_item_t nxt;
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        normalise_byte(in_ch.in_byte, in_ch.last);
        sent++;
        if (in_ch.last) patterns_done++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending.size() == 0 || ((sent == 30 || sent == 1500) && due.size() != 0) ||
            (!burst_window() && $urandom_range(0, 99) < 28)) begin
          in_ch.valid <= 1'b0;
        end else begin
          nxt = pending.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.in_byte <= nxt.b;
          in_ch.last <= nxt.fin;
        end
      end
    end
  end

  always @(posedge clk) begin : watch
    result_t want;
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        checked++;
        if (out_ch.end_mark === 1'b1) status_seen[out_ch.status]++;
        if (due.size() == 0) begin
          flag($sformatf("unexpected output transaction: out_byte %0h end_mark %0b status %0d",
                         out_ch.out_byte, out_ch.end_mark, out_ch.status));
        end else begin
          want = due.pop_front();
          check_field("out_byte", want.out_byte, out_ch.out_byte);
          check_field("byte_valid", 8'(want.byte_valid), 8'(out_ch.byte_valid));
          check_field("end_mark", 8'(want.end_mark), 8'(out_ch.end_mark));
          check_field("status", 8'(want.status), 8'(out_ch.status));
        end
      end
      out_ch.ready <= burst_window() || $urandom_range(0, 99) >= 28;
    end
  end

  initial begin : stim
    int kind;
    int pos;
    int short_total;
    bit long_done;
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'h00;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
    short_total = 0;
    long_done = 1'b0;

    pat.push_back(8'hFF);
    flush_pattern();
    directed("/:id");
    directed("/:");
    directed("/{");
    directed("/{{");
    directed("/}");
    directed("/{}");
    directed("/:a(");
    directed("/{a:}");
    directed("/x:a");
    directed("/:a((b))c");

    while (short_total < 1950) begin
      if (!long_done && short_total > 800) begin
        // last byte is the one that reaches the length limit
        add_long(int'(MAX_LEN));
        short_total += int'(MAX_LEN);
        long_done = 1'b1;
      end
      kind = $urandom_range(0, 99);
      if (kind < 90) begin
        gen_route();
        if (kind >= 70) begin
          pos = $urandom_range(0, pat.size() - 1);
          if ($urandom_range(0, 1)) pat[pos] = rnd_special();
          else while (pat.size() > pos + 1) pat.delete(pat.size() - 1);
        end
      end else begin
        pat.push_back($urandom_range(0, 1) ? CH_SLASH : 8'($urandom_range(0, 255)));
        repeat ($urandom_range(0, 11))
          pat.push_back($urandom_range(0, 3) == 0 ? rnd_special() : 8'($urandom_range(0, 255)));
      end
      short_total += pat.size();
      flush_pattern();
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || in_ch.valid) @(posedge clk);
    while (due.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d bytes in %0d patterns, checked %0d output transactions, %0d mismatches.",
             sent, patterns_done, checked, mismatches);
    $display("End status counts ok/start/long/unclosed/nested/empty/stray/unterm: %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7]);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
